// ----- hdl/hfsrgb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfsrgb_pkg
// Shared types, field widths and the sRGB threshold table for the converter.
// ----------------------------------------------------------------------------
package hfsrgb_pkg;

  localparam int unsigned PixelWidth = 64;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned HalfWidth  = 16;
  localparam int unsigned MagWidth   = 15;
  localparam int unsigned CodeMax    = 255;
  localparam int unsigned WideWidth  = 384;

  localparam logic [MagWidth-1:0] HalfOne = 15'h3C00;

  typedef enum logic {
    MODE_BGRA8 = 1'b0,
    MODE_HALF  = 1'b1
  } source_mode_t;

  typedef logic [MagWidth-1:0]        mag_t;
  typedef mag_t [CodeMax:1]           thr_table_t;
  typedef logic [ChanWidth-1:0]       chan_t;
  typedef logic [WideWidth-1:0]       wide_t;

  // does the curve give at least code k for half magnitude h (exact integer test)
  function automatic logic code_reaches(input mag_t h, input int unsigned k);
    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [63:0] m;
    int unsigned s;
    logic [63:0] lin_l;
    logic [63:0] lin_r;
    wide_t       lhs;
    wide_t       rhs;
    logic        res;
    expo = h[14:10];
    frac = h[9:0];
    res  = 1'b0;
    if (h >= HalfOne) begin
      res = 1'b1;
    end else if (h == '0) begin
      res = 1'b0;
    end else begin
      if (expo == 5'd0) begin
        m = 64'(frac);
        s = 24;
      end else begin
        m = 64'(frac) + 64'd1024;
        s = 25 - int'(expo);
      end
      lin_l = m * 64'd10000000;
      lin_r = 64'd31308 << s;
      if (lin_l <= lin_r) begin
        res = ((64'd32946 * m) + (64'd5 << s)) >= (64'(k) * (64'd10 << s));
      end else begin
        lhs = wide_t'(1);
        rhs = wide_t'(1);
        for (int i = 0; i < 5; i++) begin
          lhs = lhs * wide_t'(m);
        end
        for (int i = 0; i < 12; i++) begin
          lhs = lhs * wide_t'(53805);
          rhs = rhs * wide_t'(200 * k + 2705);
        end
        rhs = rhs << (5 * s);
        res = (lhs >= rhs);
      end
    end
    return res;
  endfunction

  // smallest half magnitude that reaches each code, worked out at elaboration
  function automatic thr_table_t build_thresholds();
    thr_table_t  tbl;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int unsigned k = 1; k <= CodeMax; k++) begin
      lo = 1;
      hi = int'(HalfOne);
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (code_reaches(mag_t'(mid), k)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tbl[k] = mag_t'(lo);
    end
    return tbl;
  endfunction

  localparam thr_table_t SrgbThresh = build_thresholds();

endpackage
`default_nettype wire

// ----- hdl/half_float_to_srgb8_pixel_convert.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// half_float_to_srgb8_pixel_convert
// Converts one captured pixel (BGRA8 or half-float RGBA) to 8-bit sRGB RGB.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one 64-bit pixel; output beats on m_axis carry
// red, green and blue codes. cfg_wr_en/cfg_wr_data set the source format
// (0 = BGRA8, 1 = half-float) and should only change while the block is empty.
// A beat accepted on s_axis is captured in the input register, converted (in
// half-float mode) by a bank of magnitude comparators against a constant sRGB
// threshold table and moved into the output register, offered on m_axis, when
// that register frees up. One pixel per clock is sustained when not stalled.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more beat; s_axis_tready drops only when both
// are full. Reset empties both registers and selects BGRA8 mode.
// ----------------------------------------------------------------------------
module half_float_to_srgb8_pixel_convert (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic                             cfg_wr_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_word
  input  wire logic [hfsrgb_pkg::PixelWidth-1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // red_out, green_out, blue_out
  output logic [3*hfsrgb_pkg::ChanWidth-1:0]    m_axis_tdata
);
  import hfsrgb_pkg::*;

  source_mode_t            source_mode;
  logic                    in_valid;
  logic [PixelWidth-1:0]   in_pixel;
  logic                    out_free;
  logic                    in_move;
  chan_t                   red_next;
  chan_t                   green_next;
  chan_t                   blue_next;

  function automatic chan_t half_code(input logic [HalfWidth-1:0] h);
    logic [CodeMax:1] hit;
    chan_t            code;
    chan_t            cand;
    logic             nan;
    for (int k = 1; k <= int'(CodeMax); k++) begin
      hit[k] = (h[MagWidth-1:0] >= SrgbThresh[k]);
    end
    code = '0;
    for (int b = ChanWidth - 1; b >= 0; b--) begin
      cand = code | chan_t'(1 << b);
      if (hit[cand]) begin
        code = cand;
      end
    end
    nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    if (h[HalfWidth-1] || nan) begin
      code = '0;
    end
    return code;
  endfunction

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_move       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // channel conversion
  always_comb begin
    if (source_mode == MODE_HALF) begin
      red_next   = half_code(in_pixel[15:0]);
      green_next = half_code(in_pixel[31:16]);
      blue_next  = half_code(in_pixel[47:32]);
    end else begin
      red_next   = in_pixel[23:16];
      green_next = in_pixel[15:8];
      blue_next  = in_pixel[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode <= MODE_BGRA8;
    end else if (cfg_wr_en) begin
      source_mode <= source_mode_t'(cfg_wr_data);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pixel <= s_axis_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      m_axis_tdata <= {blue_next, green_next, red_next};
    end
  end

endmodule
`default_nettype wire
